### rtl/ecwm_pkg.sv
// Package: constants, payload words, state type for the co-occurrence matrix unit.
package ecwm_pkg;

  localparam int RING_DEPTH = 64;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int FILL_W     = $clog2(RING_DEPTH + 1);
  localparam int MAX_BITS   = 24;
  localparam int BIT_IDX_W  = 5;
  localparam int CNT_W      = 16;
  localparam int TIME_W     = 32;
  localparam int ROW_W      = MAX_BITS * CNT_W;
  localparam int STAMP_W    = TIME_W + MAX_BITS;

  localparam logic [31:0] WINDOW_RST = 32'd2000;
  localparam logic [4:0]  ACTIVE_RST = 5'd24;

  localparam logic [1:0] REQ_EVENT = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic CFG_WINDOW = 1'b0;
  localparam logic CFG_ACTIVE = 1'b1;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [TIME_W-1:0]   now_ms;
    logic [MAX_BITS-1:0] event_bits;
    logic [4:0]          row;
    logic [4:0]          col;
  } in_word_t;

  typedef struct packed {
    logic [CNT_W-1:0]  cell_count;
    logic [FILL_W-1:0] matched_stamps;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RING_RD,
    ST_RING_CHK,
    ST_PUSH,
    ST_ROW_RD,
    ST_ROW_WR,
    ST_CELL_RD,
    ST_CELL_OUT,
    ST_DONE
  } state_t;

endpackage

### rtl/ecwm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ecwm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/event_cooccurrence_window_matrix_unit.sv
// Top level: event co-occurrence window matrix unit.
// Event: one read per stamp from the ring (up to 64, including the first stamp
//   past the window), a visit to each of the 24 matrix rows plus a write per tracked
//   row set in the event, plus accept, push and output steps. The ring walk dominates.
// Read: matrix row read, then output. Clear and other requests: output only. One word in flight.
// Reset: synchronous; ring empty, all matrix rows invalid (read as zero),
//   registers back to window 2000 ms and 24 active bits. No clearing pass.
module event_cooccurrence_window_matrix_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ecwm_pkg::in_word_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ecwm_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);

  ecwm_pkg::state_t state_r, state_nxt;

  logic [31:0] window_r;
  logic [4:0]  active_r;

  ecwm_pkg::in_word_t req_r, req_nxt;
  logic [ecwm_pkg::RING_AW-1:0] head_r, head_nxt;
  logic [ecwm_pkg::FILL_W-1:0]  fill_r, fill_nxt;
  logic [ecwm_pkg::FILL_W-1:0]  k_r, k_nxt;
  logic [ecwm_pkg::FILL_W-1:0]  matched_r, matched_nxt;
  logic [ecwm_pkg::CNT_W-1:0]   cell_r, cell_nxt;
  logic [ecwm_pkg::BIT_IDX_W-1:0] r_r, r_nxt;
  logic [ecwm_pkg::MAX_BITS-1:0] row_vld_r, row_vld_nxt;
  logic [ecwm_pkg::FILL_W-1:0]  colcnt_r [ecwm_pkg::MAX_BITS];
  logic [ecwm_pkg::FILL_W-1:0]  colcnt_nxt [ecwm_pkg::MAX_BITS];

  logic                out_valid_r;
  ecwm_pkg::out_word_t out_r;
  logic                out_load;

  logic [4:0]                   n_eff;
  logic [ecwm_pkg::MAX_BITS-1:0] mask;
  logic [ecwm_pkg::MAX_BITS-1:0] a_bits;

  logic                          ring_we;
  logic [ecwm_pkg::RING_AW-1:0]  ring_raddr;
  logic [ecwm_pkg::STAMP_W-1:0]  ring_rdata;
  logic [ecwm_pkg::TIME_W-1:0]   st_time;
  logic [ecwm_pkg::MAX_BITS-1:0] st_bits;
  logic [ecwm_pkg::TIME_W-1:0]   age;

  logic                          mx_we;
  logic [ecwm_pkg::BIT_IDX_W-1:0] mx_raddr;
  logic [ecwm_pkg::ROW_W-1:0]    mx_rdata;
  logic [ecwm_pkg::ROW_W-1:0]    mx_old;
  logic [ecwm_pkg::ROW_W-1:0]    mx_wdata;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ecwm_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign n_eff = (active_r > 5'(ecwm_pkg::MAX_BITS)) ? 5'(ecwm_pkg::MAX_BITS) : active_r;

  always_comb begin
    for (int i = 0; i < ecwm_pkg::MAX_BITS; i++) begin
      mask[i] = (5'(i) < n_eff);
    end
  end

  assign a_bits  = req_r.event_bits & mask;
  assign st_time = ring_rdata[ecwm_pkg::STAMP_W-1 -: ecwm_pkg::TIME_W];
  assign st_bits = ring_rdata[ecwm_pkg::MAX_BITS-1:0];
  assign age     = req_r.now_ms - st_time;
  assign ring_we = (state_r == ecwm_pkg::ST_PUSH);
  assign ring_raddr = head_r - ecwm_pkg::RING_AW'(1) - k_r[ecwm_pkg::RING_AW-1:0];
  assign mx_we    = (state_r == ecwm_pkg::ST_ROW_WR);
  assign mx_raddr = (state_r == ecwm_pkg::ST_CELL_RD) ? req_r.row : r_r;
  assign mx_old   = row_vld_r[r_r] ? mx_rdata : '0;

  always_comb begin
    for (int c = 0; c < ecwm_pkg::MAX_BITS; c++) begin
      mx_wdata[c*ecwm_pkg::CNT_W +: ecwm_pkg::CNT_W] =
        mx_old[c*ecwm_pkg::CNT_W +: ecwm_pkg::CNT_W] + ecwm_pkg::CNT_W'(colcnt_r[c]);
    end
  end

  ecwm_ram #(.WIDTH(ecwm_pkg::STAMP_W), .DEPTH(ecwm_pkg::RING_DEPTH)) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (head_r),
    .wdata ({req_r.now_ms, req_r.event_bits}),
    .raddr (ring_raddr),
    .rdata (ring_rdata)
  );

  ecwm_ram #(.WIDTH(ecwm_pkg::ROW_W), .DEPTH(ecwm_pkg::MAX_BITS)) u_matrix (
    .clk   (clk),
    .we    (mx_we),
    .waddr (r_r),
    .wdata (mx_wdata),
    .raddr (mx_raddr),
    .rdata (mx_rdata)
  );

  always_comb begin
    state_nxt   = state_r;
    req_nxt     = req_r;
    head_nxt    = head_r;
    fill_nxt    = fill_r;
    k_nxt       = k_r;
    matched_nxt = matched_r;
    cell_nxt    = cell_r;
    r_nxt       = r_r;
    row_vld_nxt = row_vld_r;
    colcnt_nxt  = colcnt_r;
    out_load    = 1'b0;
    case (state_r)
      ecwm_pkg::ST_IDLE: begin
        if (in_valid) begin
          req_nxt     = in_data;
          k_nxt       = '0;
          matched_nxt = '0;
          cell_nxt    = '0;
          r_nxt       = '0;
          for (int c = 0; c < ecwm_pkg::MAX_BITS; c++) begin
            colcnt_nxt[c] = '0;
          end
          state_nxt = ecwm_pkg::ST_DONE;
          case (in_data.req_type)
            ecwm_pkg::REQ_EVENT: begin
              if (in_data.event_bits != '0) begin
                state_nxt = (fill_r == '0) ? ecwm_pkg::ST_PUSH : ecwm_pkg::ST_RING_RD;
              end
            end
            ecwm_pkg::REQ_READ: begin
              state_nxt = ecwm_pkg::ST_CELL_RD;
            end
            ecwm_pkg::REQ_CLEAR: begin
              head_nxt    = '0;
              fill_nxt    = '0;
              row_vld_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ecwm_pkg::ST_RING_RD: begin
        state_nxt = ecwm_pkg::ST_RING_CHK;
      end
      ecwm_pkg::ST_RING_CHK: begin
        if (age > window_r) begin
          state_nxt = ecwm_pkg::ST_PUSH;
        end else begin
          matched_nxt = matched_r + 1'b1;
          for (int c = 0; c < ecwm_pkg::MAX_BITS; c++) begin
            colcnt_nxt[c] = colcnt_r[c] + ecwm_pkg::FILL_W'(st_bits[c] & mask[c]);
          end
          k_nxt = k_r + 1'b1;
          state_nxt = (k_r + 1'b1 == fill_r) ? ecwm_pkg::ST_PUSH : ecwm_pkg::ST_RING_RD;
        end
      end
      ecwm_pkg::ST_PUSH: begin
        head_nxt = head_r + 1'b1;
        if (fill_r != ecwm_pkg::FILL_W'(ecwm_pkg::RING_DEPTH)) begin
          fill_nxt = fill_r + 1'b1;
        end
        state_nxt = ecwm_pkg::ST_ROW_RD;
      end
      ecwm_pkg::ST_ROW_RD: begin
        if (a_bits[r_r]) begin
          state_nxt = ecwm_pkg::ST_ROW_WR;
        end else if (r_r == 5'(ecwm_pkg::MAX_BITS - 1)) begin
          state_nxt = ecwm_pkg::ST_DONE;
        end else begin
          r_nxt = r_r + 1'b1;
        end
      end
      ecwm_pkg::ST_ROW_WR: begin
        row_vld_nxt[r_r] = 1'b1;
        if (r_r == 5'(ecwm_pkg::MAX_BITS - 1)) begin
          state_nxt = ecwm_pkg::ST_DONE;
        end else begin
          r_nxt     = r_r + 1'b1;
          state_nxt = ecwm_pkg::ST_ROW_RD;
        end
      end
      ecwm_pkg::ST_CELL_RD: begin
        state_nxt = ecwm_pkg::ST_CELL_OUT;
      end
      ecwm_pkg::ST_CELL_OUT: begin
        if (req_r.row < n_eff && req_r.col < n_eff && row_vld_r[req_r.row]) begin
          cell_nxt = mx_rdata[req_r.col*ecwm_pkg::CNT_W +: ecwm_pkg::CNT_W];
        end
        state_nxt = ecwm_pkg::ST_DONE;
      end
      ecwm_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ecwm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ecwm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ecwm_pkg::ST_IDLE;
      window_r    <= ecwm_pkg::WINDOW_RST;
      active_r    <= ecwm_pkg::ACTIVE_RST;
      head_r      <= '0;
      fill_r      <= '0;
      row_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      fill_r    <= fill_nxt;
      row_vld_r <= row_vld_nxt;
      if (cfg_valid) begin
        if (cfg_index == ecwm_pkg::CFG_WINDOW) begin
          window_r <= cfg_data;
        end else begin
          active_r <= cfg_data[4:0];
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    k_r       <= k_nxt;
    matched_r <= matched_nxt;
    cell_r    <= cell_nxt;
    r_r       <= r_nxt;
    colcnt_r  <= colcnt_nxt;
    if (out_load) begin
      out_r.cell_count     <= cell_r;
      out_r.matched_stamps <= matched_r;
    end
  end

endmodule
